@@ rtl/pfdp_pkg.sv @@
// Shared types, widths and codes for the packet FIFO with drop policy.
`default_nettype none
package pfdp_pkg;

   localparam int DEPTH = 32;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W = 16;
   localparam int BYTES_W = 16;
   localparam int TOTAL_W = $clog2(DEPTH * ((1 << BYTES_W) - 1) + 1);
   localparam int DROP_W = 32;
   localparam int MAXPK_W = 6;
   localparam int MAXBY_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int KIND_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PACKETS = 2'd0,
      CSR_MAX_BYTES   = 2'd1,
      CSR_DROP_POLICY = 2'd2
   } csr_idx_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic {
      POLICY_TAIL_DROP = 1'b0,
      POLICY_HEAD_DROP = 1'b1
   } policy_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_TAIL_DROP = 3'd1,
      KIND_EVICTED = 3'd2,
      KIND_DEQUEUED = 3'd3,
      KIND_EMPTY = 3'd4
   } kind_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      entry_type        entry;
   } mem_wr_type;

endpackage
`default_nettype wire

@@ rtl/pfdp_if.sv @@
// Channel interfaces: enqueue/dequeue requests, results and register writes.
`default_nettype none
interface pfdp_req_if import pfdp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [ID_W-1:0]    pkt_id;
   logic [BYTES_W-1:0] pkt_bytes;

   modport source (output valid, op, pkt_id, pkt_bytes, input ready);
   modport sink (input valid, op, pkt_id, pkt_bytes, output ready);
endinterface

interface pfdp_rsp_if import pfdp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [ID_W-1:0]    out_id;
   logic [BYTES_W-1:0] out_bytes;
   logic [CNT_W-1:0]   queued_packets;
   logic [TOTAL_W-1:0] queued_bytes;
   logic [DROP_W-1:0]  overflow_count;
   logic               last;

   modport source (output valid, kind, out_id, out_bytes, queued_packets, queued_bytes,
                   overflow_count, last, input ready);
   modport sink (input valid, kind, out_id, out_bytes, queued_packets, queued_bytes,
                 overflow_count, last, output ready);
endinterface

interface pfdp_csr_if import pfdp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/packet_fifo_drop_policy_core.sv @@
// Packet FIFO with tail-drop or head-drop overflow handling.
//
// req: one transaction is an enqueue (id and byte size) or a dequeue.
// rsp: one transaction per action; last marks the final result of a request.
//   An enqueue under head-drop may first give one evicted result per removed
//   packet, then the accepted or tail-dropped result for the arriving packet.
// csr: register writes (max_packets, max_bytes, drop_policy), always ready;
//   write only while no request is in flight.
// Sequence: a request is taken in S_IDLE and its first result is loaded
//   into the output register in S_EVAL once that register is free. Each
//   eviction passes through S_WAIT, since the packet store has a registered
//   read port and is re-read after the head moves.
// A new request is taken only after the previous one has given its last
//   result to the output register. When rsp stalls, the result is held and
//   the block waits with it.
// Reset empties the queue and clears the overflow count, limits, policy and rsp valid.
`default_nettype none
module packet_fifo_drop_policy_core import pfdp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   pfdp_req_if.sink   req_if,
   pfdp_rsp_if.source rsp_if,
   pfdp_csr_if.sink   csr_if
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WAIT
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [MAXPK_W-1:0] max_pk_ff, max_pk_in;
   logic [MAXBY_W-1:0] max_by_ff, max_by_in;
   logic               policy_ff, policy_in;
   logic               op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [DROP_W-1:0]  rsp_drop_ff, rsp_drop_in;
   logic               rsp_last_ff, rsp_last_in;

   mem_wr_type         wr;
   entry_type          head_entry;
   logic               out_free;
   logic [CNT_W-1:0]   cnt_limit;
   logic               cnt_over;
   logic               vol_over;
   logic               over;
   logic [PTR_W-1:0]   head_next;
   logic [PTR_W-1:0]   tail_next;
   logic [DROP_W-1:0]  drop_bump;

   pfdp_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (head_ff),
      .rd_entry (head_entry)
   );

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign cnt_limit = (max_pk_ff == '0 || 32'(max_pk_ff) > 32'(DEPTH)) ?
                      CNT_W'(DEPTH) : CNT_W'(max_pk_ff);
   assign cnt_over  = ({1'b0, count_ff} + (CNT_W+1)'(1)) > {1'b0, cnt_limit};
   assign vol_over  = (max_by_ff != '0) &&
                      ((33'(total_ff) + 33'(bytes_ff)) > 33'(max_by_ff));
   assign over      = cnt_over || vol_over;
   assign head_next = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_next = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign drop_bump = (drop_ff != '1) ? drop_ff + DROP_W'(1) : drop_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      drop_in      = drop_ff;
      max_pk_in    = max_pk_ff;
      max_by_in    = max_by_ff;
      policy_in    = policy_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      bytes_in     = bytes_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_total_in = rsp_total_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;
      wr           = '0;

      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_MAX_PACKETS: max_pk_in = csr_if.data[MAXPK_W-1:0];
            CSR_MAX_BYTES:   max_by_in = csr_if.data[MAXBY_W-1:0];
            CSR_DROP_POLICY: policy_in = csr_if.data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.op;
               id_in    = req_if.pkt_id;
               bytes_in = req_if.pkt_bytes;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == OP_DEQUEUE) begin
                  if (count_ff == '0) begin
                     rsp_kind_in  = KIND_EMPTY;
                     rsp_id_in    = '0;
                     rsp_bytes_in = '0;
                  end else begin
                     head_in      = head_next;
                     count_in     = count_ff - CNT_W'(1);
                     total_in     = total_ff - TOTAL_W'(head_entry.bytes);
                     rsp_kind_in  = KIND_DEQUEUED;
                     rsp_id_in    = head_entry.id;
                     rsp_bytes_in = head_entry.bytes;
                  end
               end else if (policy_ff == POLICY_HEAD_DROP && count_ff != '0 && over) begin
                  head_in      = head_next;
                  count_in     = count_ff - CNT_W'(1);
                  total_in     = total_ff - TOTAL_W'(head_entry.bytes);
                  drop_in      = drop_bump;
                  rsp_kind_in  = KIND_EVICTED;
                  rsp_id_in    = head_entry.id;
                  rsp_bytes_in = head_entry.bytes;
                  rsp_last_in  = 1'b0;
                  state_in     = S_WAIT;
               end else if (!over) begin
                  wr.en        = 1'b1;
                  wr.addr      = tail_ff;
                  wr.entry.id  = id_ff;
                  wr.entry.bytes = bytes_ff;
                  tail_in      = tail_next;
                  count_in     = count_ff + CNT_W'(1);
                  total_in     = total_ff + TOTAL_W'(bytes_ff);
                  rsp_kind_in  = KIND_ACCEPTED;
                  rsp_id_in    = id_ff;
                  rsp_bytes_in = bytes_ff;
               end else begin
                  drop_in      = drop_bump;
                  rsp_kind_in  = KIND_TAIL_DROP;
                  rsp_id_in    = id_ff;
                  rsp_bytes_in = bytes_ff;
               end
               rsp_cnt_in   = count_in;
               rsp_total_in = total_in;
               rsp_drop_in  = drop_in;
            end
         end
         S_WAIT: begin
            state_in = S_EVAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         drop_ff      <= '0;
         max_pk_ff    <= '0;
         max_by_ff    <= '0;
         policy_ff    <= POLICY_TAIL_DROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         max_pk_ff    <= max_pk_in;
         max_by_ff    <= max_by_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      id_ff        <= id_in;
      bytes_ff     <= bytes_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_total_ff <= rsp_total_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_kind_ff;
   assign rsp_if.out_id         = rsp_id_ff;
   assign rsp_if.out_bytes      = rsp_bytes_ff;
   assign rsp_if.queued_packets = rsp_cnt_ff;
   assign rsp_if.queued_bytes   = rsp_total_ff;
   assign rsp_if.overflow_count = rsp_drop_ff;
   assign rsp_if.last           = rsp_last_ff;

   a_not_last_is_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_kind_ff == KIND_EVICTED)
      else $error("non-final result is not an eviction");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("packet count exceeds store depth");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> total_ff == '0)
      else $error("empty queue holds bytes");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == S_EVAL)
      else $error("accepted transaction not evaluated");

   a_drop_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> drop_ff >= $past(drop_ff))
      else $error("overflow count decreased");

endmodule
`default_nettype wire

@@ rtl/pfdp_store.sv @@
// Packet id and size store: one write port, one registered read port.
`default_nettype none
module pfdp_store import pfdp_pkg::*; (
   input  wire logic             clock,
   input  wire mem_wr_type       wr,
   input  wire logic [PTR_W-1:0] rd_addr,
   output entry_type             rd_entry
);

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the packet FIFO core under tail-drop and head-drop limits.
module testbench;
   import pfdp_pkg::*;

   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int TAIL_CYCLES     = 10;
   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 39;
   localparam int FILL_PHASE      = 0;
   localparam int HOLD_PHASE      = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   localparam logic [MAXPK_W-1:0] PHASE_MAX_PACKETS [NUM_PHASES] =
      '{6'd0, 6'd63, 6'd1, 6'd32, 6'd17, 6'd45, 6'd5};
   localparam logic [MAXBY_W-1:0] PHASE_MAX_BYTES [NUM_PHASES] =
      '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd150000, 32'd40000, 32'd0, 32'd300};
   localparam policy_type PHASE_POLICY [NUM_PHASES] =
      '{POLICY_HEAD_DROP, POLICY_TAIL_DROP, POLICY_HEAD_DROP, POLICY_HEAD_DROP,
        POLICY_TAIL_DROP, POLICY_HEAD_DROP, POLICY_TAIL_DROP};
   localparam int PHASE_ENQ_PCT [NUM_PHASES] = '{90, 85, 60, 75, 70, 85, 55};
   localparam bit PHASE_TINY [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   typedef enum {RX_STEADY, RX_LIGHT, RX_ALTERNATE, RX_HEAVY} rx_mode_type;

   typedef struct {
      op_type             op;
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] bytes;
   } pkt_request_type;

   typedef struct {
      kind_type           kind;
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] bytes;
      logic [CNT_W-1:0]   packets;
      logic [TOTAL_W-1:0] total;
      logic [DROP_W-1:0]  drops;
      logic               last;
   } fifo_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfdp_req_if req_bus ();
   pfdp_rsp_if rsp_bus ();
   pfdp_csr_if csr_bus ();

   packet_fifo_drop_policy_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue image kept alongside the block
   logic [ID_W-1:0]    q_id [DEPTH];
   logic [BYTES_W-1:0] q_size [DEPTH];
   logic [PTR_W-1:0]   q_head = '0;
   logic [PTR_W-1:0]   q_tail = '0;
   logic [CNT_W-1:0]   q_count = '0;
   logic [TOTAL_W-1:0] q_total = '0;
   logic [DROP_W-1:0]  q_drops = '0;
   logic [MAXPK_W-1:0] cfg_max_packets = '0;
   logic [MAXBY_W-1:0] cfg_max_bytes = '0;
   policy_type         cfg_policy = POLICY_TAIL_DROP;

   pkt_request_type  pending_reqs [$];
   fifo_outcome_type expected_results [$];
   pkt_request_type  taken_req;
   fifo_outcome_type next_outcome;

   int mismatches = 0;
   int requests_sent = 0;
   int kind_count [5] = '{0, 0, 0, 0, 0};
   int longest_evictions = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_left = 0;
   int pattern_left = 0;
   rx_mode_type rx_mode = RX_STEADY;
   bit rx_toggle = 1'b0;
   int idle_cycles = 0;

   function automatic logic exceeds_limit(input logic [BYTES_W-1:0] b);
      int unsigned lim;
      lim = (cfg_max_packets == 0 || cfg_max_packets > DEPTH) ? DEPTH : cfg_max_packets;
      return ((32'(q_count) + 32'd1) > lim) ||
             (cfg_max_bytes != 0 && (64'(q_total) + 64'(b)) > 64'(cfg_max_bytes));
   endfunction

   function automatic void pop_oldest(output logic [ID_W-1:0] id,
                                      output logic [BYTES_W-1:0] bytes);
      id = q_id[q_head];
      bytes = q_size[q_head];
      q_head = (q_head == PTR_W'(DEPTH - 1)) ? '0 : q_head + 1'b1;
      q_count = q_count - 1'b1;
      q_total = q_total - TOTAL_W'(bytes);
   endfunction

   function automatic void note_outcome(input kind_type kind, input logic [ID_W-1:0] id,
                                        input logic [BYTES_W-1:0] bytes, input logic last);
      fifo_outcome_type o;
      o.kind = kind;
      o.id = id;
      o.bytes = bytes;
      o.packets = q_count;
      o.total = q_total;
      o.drops = q_drops;
      o.last = last;
      expected_results.push_back(o);
   endfunction

   function automatic void predict_item(input pkt_request_type r);
      logic [ID_W-1:0]    gone_id;
      logic [BYTES_W-1:0] gone_bytes;
      int                 evicted;
      evicted = 0;
      if (r.op == OP_DEQUEUE) begin
         if (q_count == 0) begin
            note_outcome(KIND_EMPTY, '0, '0, 1'b1);
         end else begin
            pop_oldest(gone_id, gone_bytes);
            note_outcome(KIND_DEQUEUED, gone_id, gone_bytes, 1'b1);
         end
      end else begin
         if (cfg_policy == POLICY_HEAD_DROP) begin
            while (q_count != 0 && exceeds_limit(r.bytes)) begin
               pop_oldest(gone_id, gone_bytes);
               if (q_drops != '1) q_drops = q_drops + 1'b1;
               note_outcome(KIND_EVICTED, gone_id, gone_bytes, 1'b0);
               evicted++;
            end
         end
         if (!exceeds_limit(r.bytes)) begin
            q_id[q_tail] = r.id;
            q_size[q_tail] = r.bytes;
            q_tail = (q_tail == PTR_W'(DEPTH - 1)) ? '0 : q_tail + 1'b1;
            q_count = q_count + 1'b1;
            q_total = q_total + TOTAL_W'(r.bytes);
            note_outcome(KIND_ACCEPTED, r.id, r.bytes, 1'b1);
         end else begin
            if (q_drops != '1) q_drops = q_drops + 1'b1;
            note_outcome(KIND_TAIL_DROP, r.id, r.bytes, 1'b1);
         end
      end
      if (evicted > longest_evictions) longest_evictions = evicted;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [BYTES_W-1:0] pick_bytes(input bit tiny);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (tiny) return (roll < 8) ? {BYTES_W{1'b0}} : BYTES_W'($urandom);
      case (roll)
         0: return {BYTES_W{1'b0}};
         1: return {BYTES_W{1'b1}};
         2, 3: return BYTES_W'($urandom_range(0, 3));
         4, 5, 6: return BYTES_W'($urandom_range(0, 4000));
         default: return BYTES_W'($urandom);
      endcase
   endfunction

   task automatic queue_item(input op_type op, input logic [ID_W-1:0] id,
                             input logic [BYTES_W-1:0] bytes);
      pkt_request_type r;
      r.op = op;
      r.id = id;
      r.bytes = bytes;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_results.size() != 0 || req_bus.valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // call at a rising edge; the spare index must be ignored by the block
   task automatic write_limits(input logic [MAXPK_W-1:0] mp, input logic [MAXBY_W-1:0] mb,
                               input policy_type pol);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      logic [31:0]           noise;
      noise = $urandom();
      idx[0] = CSR_MAX_PACKETS;
      val[0] = {noise[31:MAXPK_W], mp};
      idx[1] = CSR_SPARE_IDX;
      val[1] = $urandom();
      idx[2] = CSR_MAX_BYTES;
      val[2] = mb;
      noise = $urandom();
      idx[3] = CSR_DROP_POLICY;
      val[3] = {noise[31:1], pol};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.data <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
         case (idx[i])
            CSR_MAX_PACKETS: cfg_max_packets = val[i][MAXPK_W-1:0];
            CSR_MAX_BYTES:   cfg_max_bytes = val[i][MAXBY_W-1:0];
            CSR_DROP_POLICY: cfg_policy = policy_type'(val[i][0]);
            default: ;
         endcase
      end
      csr_bus.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken_req = pending_reqs.pop_front();
            predict_item(taken_req);
            requests_sent++;
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            req_bus.valid <= 1'b1;
            req_bus.op <= pending_reqs[0].op;
            req_bus.pkt_id <= pending_reqs[0].id;
            req_bus.pkt_bytes <= pending_reqs[0].bytes;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(8, 60);
            end
            pattern_left--;
            rx_toggle = ~rx_toggle;
            case (rx_mode)
               RX_STEADY:    rsp_bus.ready <= 1'b1;
               RX_LIGHT:     rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_ALTERNATE: rsp_bus.ready <= rx_toggle;
               default:      rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: kind %0d id %0d bytes %0d",
                   rsp_bus.kind, rsp_bus.out_id, rsp_bus.out_bytes);
            mismatches++;
         end else begin
            next_outcome = expected_results.pop_front();
            check_field("kind", 64'(next_outcome.kind), 64'(rsp_bus.kind));
            check_field("out_id", 64'(next_outcome.id), 64'(rsp_bus.out_id));
            check_field("out_bytes", 64'(next_outcome.bytes), 64'(rsp_bus.out_bytes));
            check_field("queued_packets", 64'(next_outcome.packets),
                        64'(rsp_bus.queued_packets));
            check_field("queued_bytes", 64'(next_outcome.total), 64'(rsp_bus.queued_bytes));
            check_field("overflow_count", 64'(next_outcome.drops),
                        64'(rsp_bus.overflow_count));
            check_field("last", 64'(next_outcome.last), 64'(rsp_bus.last));
            kind_count[next_outcome.kind]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("timeout: %0d cycles without a transaction", STALL_LIMIT);
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = OP_ENQUEUE;
      req_bus.pkt_id = '0;
      req_bus.pkt_bytes = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MAX_PACKETS;
      csr_bus.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tail drop on count limit, field extremes, empty dequeue
      write_limits(6'd2, 32'd0, POLICY_TAIL_DROP);
      @(negedge clock);
      queue_item(OP_DEQUEUE, 16'hFFFF, 16'hFFFF);
      queue_item(OP_ENQUEUE, 16'h0000, 16'h0000);
      queue_item(OP_ENQUEUE, 16'hFFFF, 16'hFFFF);
      queue_item(OP_ENQUEUE, 16'h1234, 16'd10);
      queue_item(OP_DEQUEUE, 16'($urandom), 16'($urandom));
      queue_item(OP_DEQUEUE, 16'($urandom), 16'($urandom));
      queue_item(OP_DEQUEUE, 16'($urandom), 16'($urandom));
      wait_idle();

      // evict on byte limit, oversize packet clears the queue, evict on count limit
      write_limits(6'd3, 32'd100, POLICY_HEAD_DROP);
      @(negedge clock);
      queue_item(OP_ENQUEUE, 16'd1, 16'd40);
      queue_item(OP_ENQUEUE, 16'd2, 16'd40);
      queue_item(OP_ENQUEUE, 16'd3, 16'd20);
      queue_item(OP_ENQUEUE, 16'd4, 16'd30);
      queue_item(OP_ENQUEUE, 16'd5, 16'd101);
      queue_item(OP_ENQUEUE, 16'd6, 16'd100);
      queue_item(OP_ENQUEUE, 16'd7, 16'd0);
      queue_item(OP_ENQUEUE, 16'd8, 16'd0);
      queue_item(OP_ENQUEUE, 16'd9, 16'd0);
      queue_item(OP_DEQUEUE, 16'($urandom), 16'($urandom));

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_limits(PHASE_MAX_PACKETS[p], PHASE_MAX_BYTES[p], PHASE_POLICY[p]);
         @(negedge clock);
         if (p == HOLD_PHASE) hold_off_requests++;
         if (p == FILL_PHASE) begin
            // fill past depth with empty packets, then flush it with one oversize packet
            for (int i = 0; i < DEPTH + 1; i++)
               queue_item(OP_ENQUEUE, 16'($urandom), 16'd0);
            queue_item(OP_ENQUEUE, 16'($urandom), 16'($urandom_range(2, 65535)));
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_item(($urandom_range(0, 99) < PHASE_ENQ_PCT[p]) ? OP_ENQUEUE : OP_DEQUEUE,
                       16'($urandom), pick_bytes(PHASE_TINY[p]));
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d requests over %0d limit settings; %0d accepted, %0d tail-dropped,",
               requests_sent, NUM_PHASES + 2, kind_count[KIND_ACCEPTED],
               kind_count[KIND_TAIL_DROP]);
      $display("summary: %0d evicted (longest run %0d), %0d dequeued, %0d empty reads",
               kind_count[KIND_EVICTED], longest_evictions, kind_count[KIND_DEQUEUED],
               kind_count[KIND_EMPTY]);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
